### hdl/assert_macros.svh
// Assertion macros for the segment intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, disabled in reset.
`define SIT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment intersection assertion failed");
// Plain property, clocked on clk, disabled in reset.
`define SIT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("segment intersection assertion failed");
`else
`define SIT_ASSERT_IMP(lbl, ante, cons)
`define SIT_ASSERT(lbl, prop)
`endif
`endif

### hdl/sit_pkg.sv
// Types and widths for the segment intersection pipeline.
`default_nettype none
package sit_pkg;
  localparam int C   = 16;          // coordinate width
  localparam int DW  = C + 1;       // coordinate difference
  localparam int PW  = 2 * C + 2;   // product of two differences
  localparam int SW  = 2 * C + 3;   // cross-product sums
  localparam int ADW = 2 * C + 2;   // magnitude of denominator
  localparam int QW  = C + 1;       // quotient bits, one cell each
  localparam int NW  = ADW + QW;    // dividend
  localparam int EW  = C + 3;       // rounding arithmetic

  typedef struct packed {
    logic signed [C-1:0] first_start_x;
    logic signed [C-1:0] first_start_y;
    logic signed [C-1:0] first_end_x;
    logic signed [C-1:0] first_end_y;
    logic signed [C-1:0] second_start_x;
    logic signed [C-1:0] second_start_y;
    logic signed [C-1:0] second_end_x;
    logic signed [C-1:0] second_end_y;
  } sit_in_t;

  typedef struct packed {
    logic                hit;
    logic signed [C-1:0] point_x;
    logic signed [C-1:0] point_y;
  } sit_out_t;

  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [ADW-1:0]      den;
    logic signed [C-1:0] base_x;
    logic signed [C-1:0] base_y;
    logic                neg_x;
    logic                neg_y;
    logic [NW-1:0]       rem_x;
    logic [NW-1:0]       rem_y;
    logic [QW-1:0]       q_x;
    logic [QW-1:0]       q_y;
  } sit_lane_t;
endpackage
`default_nettype wire

### hdl/sit_front.sv
// Front stages: differences, cross products, hit test, numerators.
`default_nettype none
module sit_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire sit_pkg::sit_in_t seg,
  output sit_pkg::sit_lane_t   lane
);
  localparam int DW  = sit_pkg::DW;
  localparam int PW  = sit_pkg::PW;
  localparam int SW  = sit_pkg::SW;
  localparam int ADW = sit_pkg::ADW;
  localparam int QW  = sit_pkg::QW;
  localparam int NW  = sit_pkg::NW;
  localparam int C   = sit_pkg::C;

  // stage 1
  logic v1;
  logic signed [DW-1:0] a1, b1, c1, d1, e1, f1, g1, h1;
  logic signed [C-1:0]  x1_1, y1_1;
  // stage 2
  logic v2;
  logic signed [PW-1:0] ab2, cd2, eb2, fd2, gf2, he2;
  logic signed [DW-1:0] g2, h2;
  logic signed [C-1:0]  x1_2, y1_2;
  // stage 3
  logic v3, hit3, ng3, nh3;
  logic [ADW-1:0] den3, tn3;
  logic [QW-1:0]  ag3, ah3;
  logic signed [C-1:0] x1_3, y1_3;

  logic signed [SW-1:0] den_s, tn_s, un_s, den_a, tn_a, un_a;
  logic signed [DW-1:0] g_abs, h_abs;
  logic hit_c;

  always_comb begin
    den_s = SW'(ab2) - SW'(cd2);
    tn_s  = SW'(eb2) - SW'(fd2);
    un_s  = SW'(gf2) - SW'(he2);
    den_a = den_s[SW-1] ? -den_s : den_s;
    tn_a  = den_s[SW-1] ? -tn_s : tn_s;
    un_a  = den_s[SW-1] ? -un_s : un_s;
    hit_c = (den_a != '0) && !tn_a[SW-1] && (tn_a <= den_a) &&
            !un_a[SW-1] && (un_a <= den_a);
    g_abs = g2[DW-1] ? -g2 : g2;
    h_abs = h2[DW-1] ? -h2 : h2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      lane.valid <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      lane.valid <= v3;
    end
    a1 <= DW'(seg.first_start_x) - DW'(seg.first_end_x);
    b1 <= DW'(seg.second_start_y) - DW'(seg.second_end_y);
    c1 <= DW'(seg.first_start_y) - DW'(seg.first_end_y);
    d1 <= DW'(seg.second_start_x) - DW'(seg.second_end_x);
    e1 <= DW'(seg.first_start_x) - DW'(seg.second_start_x);
    f1 <= DW'(seg.first_start_y) - DW'(seg.second_start_y);
    g1 <= DW'(seg.first_end_x) - DW'(seg.first_start_x);
    h1 <= DW'(seg.first_end_y) - DW'(seg.first_start_y);
    x1_1 <= seg.first_start_x;
    y1_1 <= seg.first_start_y;

    ab2 <= PW'(a1) * PW'(b1);
    cd2 <= PW'(c1) * PW'(d1);
    eb2 <= PW'(e1) * PW'(b1);
    fd2 <= PW'(f1) * PW'(d1);
    gf2 <= PW'(g1) * PW'(f1);
    he2 <= PW'(h1) * PW'(e1);
    g2 <= g1;
    h2 <= h1;
    x1_2 <= x1_1;
    y1_2 <= y1_1;

    hit3 <= hit_c;
    den3 <= den_a[ADW-1:0];
    tn3  <= tn_a[ADW-1:0];
    ag3  <= unsigned'(g_abs);
    ah3  <= unsigned'(h_abs);
    ng3  <= g2[DW-1];
    nh3  <= h2[DW-1];
    x1_3 <= x1_2;
    y1_3 <= y1_2;

    lane.hit    <= hit3;
    lane.den    <= den3;
    lane.base_x <= x1_3;
    lane.base_y <= y1_3;
    lane.neg_x  <= ng3;
    lane.neg_y  <= nh3;
    lane.rem_x  <= NW'(tn3) * NW'(ag3);
    lane.rem_y  <= NW'(tn3) * NW'(ah3);
    lane.q_x    <= '0;
    lane.q_y    <= '0;
  end
endmodule
`default_nettype wire

### hdl/sit_cell.sv
// One restoring-division cell: resolves one quotient bit for x and y.
`default_nettype none
module sit_cell #(
  parameter int SH = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sit_pkg::sit_lane_t lane_in,
  output sit_pkg::sit_lane_t     lane_out
);
  localparam int NW = sit_pkg::NW;
  localparam int QW = sit_pkg::QW;

  logic [NW-1:0] dsh;
  logic ge_x, ge_y;
  logic [QW-1:0] q_x_next, q_y_next;

  always_comb begin
    dsh  = NW'(lane_in.den) << SH;
    ge_x = lane_in.rem_x >= dsh;
    ge_y = lane_in.rem_y >= dsh;
    q_x_next = lane_in.q_x;
    q_y_next = lane_in.q_y;
    q_x_next[SH] = ge_x;
    q_y_next[SH] = ge_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out.valid <= lane_in.valid;
    end
    lane_out.hit    <= lane_in.hit;
    lane_out.den    <= lane_in.den;
    lane_out.base_x <= lane_in.base_x;
    lane_out.base_y <= lane_in.base_y;
    lane_out.neg_x  <= lane_in.neg_x;
    lane_out.neg_y  <= lane_in.neg_y;
    lane_out.rem_x  <= ge_x ? lane_in.rem_x - dsh : lane_in.rem_x;
    lane_out.rem_y  <= ge_y ? lane_in.rem_y - dsh : lane_in.rem_y;
    lane_out.q_x    <= q_x_next;
    lane_out.q_y    <= q_y_next;
  end
endmodule
`default_nettype wire

### hdl/sit_round.sv
// Output stage: rounds base +/- quotient, ties away from zero.
`default_nettype none
module sit_round (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sit_pkg::sit_lane_t lane,
  output logic                   done,
  output sit_pkg::sit_out_t      result
);
  localparam int C   = sit_pkg::C;
  localparam int ADW = sit_pkg::ADW;
  localparam int EW  = sit_pkg::EW;

  function automatic logic signed [C-1:0] fix(
    input logic signed [C-1:0] base,
    input logic [sit_pkg::QW-1:0] q,
    input logic [ADW-1:0] r,
    input logic [ADW-1:0] den,
    input logic neg
  );
    logic [ADW:0] twice;
    logic gt, eq;
    logic signed [EW-1:0] s;
    logic adj;
    twice = {r, 1'b0};
    gt = twice > {1'b0, den};
    eq = twice == {1'b0, den};
    if (!neg) begin
      s = EW'(base) + signed'(EW'(q));
      adj = gt | (eq & !s[EW-1]);
      fix = C'(s + EW'(adj));
    end else begin
      s = EW'(base) - signed'(EW'(q));
      // exact half below zero (or at zero) goes further down
      adj = gt | (eq & (s[EW-1] | (s == '0)));
      fix = C'(s - EW'(adj));
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lane.valid;
    end
    result.hit <= lane.hit;
    result.point_x <= lane.hit ?
      fix(lane.base_x, lane.q_x, lane.rem_x[ADW-1:0], lane.den, lane.neg_x) : '0;
    result.point_y <= lane.hit ?
      fix(lane.base_y, lane.q_y, lane.rem_y[ADW-1:0], lane.den, lane.neg_y) : '0;
  end
endmodule
`default_nettype wire

### hdl/segment_intersection_test_top.sv
// Top level of the segment intersection pipeline.
// Usage:
//   Present a segment pair on seg with start high; busy is always low, so a
//   new item is taken on every cycle that start is high.
//   Each item gives one result on result, marked by done for one cycle.
//   Each item passes 4 front stages, 17 division cells and 1 output register.
//   Throughput: one item per cycle; the division runs as a row of 17 cells,
//   each settling one quotient bit for x and y and passing the item on.
//   hit is 1 when the closed segments meet; point_x/point_y give the point
//   on the first segment rounded to nearest, halves away from zero, and are
//   zero on a miss or for parallel segments.
//   Reset (rst, synchronous) drops every item in flight; no result follows.
//   The receiver cannot stall: results are shown once and must be taken.
`default_nettype none
`include "assert_macros.svh"
module segment_intersection_test_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire sit_pkg::sit_in_t seg,
  output logic                  done,
  output sit_pkg::sit_out_t     result
);
  localparam int QW  = sit_pkg::QW;
  localparam int LAT = QW + 5;

  sit_pkg::sit_lane_t chain [QW+1];

  assign busy = 1'b0;

  sit_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .seg   (seg),
    .lane  (chain[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    sit_cell #(.SH(QW - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .lane_in  (chain[i]),
      .lane_out (chain[i+1])
    );
  end

  sit_round u_round (
    .clk    (clk),
    .rst    (rst),
    .lane   (chain[QW]),
    .done   (done),
    .result (result)
  );

  `SIT_ASSERT_IMP(a_done_from_start, done, $past(start, LAT))
  `SIT_ASSERT_IMP(a_miss_zero, done && !result.hit, (result.point_x == '0) && (result.point_y == '0))
  `SIT_ASSERT_IMP(a_hit_rem_below_den, chain[QW].valid && chain[QW].hit, chain[QW].rem_x < sit_pkg::NW'(chain[QW].den))
  `SIT_ASSERT(a_never_busy, !busy)
endmodule
`default_nettype wire
